// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== sv/jhp_pkg.sv =====
// ---------------------------------------------------------------------------
// JPEG header parser package
// Phase codes, result kinds and the record passed from parser to output.
// ---------------------------------------------------------------------------
package jhp_pkg;

  typedef logic [2:0] kind_t;
  typedef logic [4:0] phase_t;

  // result kinds
  localparam kind_t KIND_START   = 3'd0;
  localparam kind_t KIND_QUANT   = 3'd1;
  localparam kind_t KIND_HCOUNT  = 3'd2;
  localparam kind_t KIND_HSYMBOL = 3'd3;
  localparam kind_t KIND_FRAME   = 3'd4;
  localparam kind_t KIND_COMP    = 3'd5;
  localparam kind_t KIND_SCAN    = 3'd6;
  localparam kind_t KIND_END     = 3'd7;

  // parser phases
  localparam phase_t PH_SEARCH    = 5'd0;
  localparam phase_t PH_MARK      = 5'd1;
  localparam phase_t PH_DONE      = 5'd2;
  localparam phase_t PH_SKIP_LH   = 5'd3;
  localparam phase_t PH_SKIP_LL   = 5'd4;
  localparam phase_t PH_SKIP_BODY = 5'd5;
  localparam phase_t PH_DQT_LH    = 5'd6;
  localparam phase_t PH_DQT_LL    = 5'd7;
  localparam phase_t PH_DQT_INFO  = 5'd8;
  localparam phase_t PH_DQT_ENT   = 5'd9;
  localparam phase_t PH_DHT_LH    = 5'd10;
  localparam phase_t PH_DHT_LL    = 5'd11;
  localparam phase_t PH_DHT_INFO  = 5'd12;
  localparam phase_t PH_DHT_CNT   = 5'd13;
  localparam phase_t PH_DHT_SYM   = 5'd14;
  localparam phase_t PH_SOF_HDR   = 5'd15;
  localparam phase_t PH_SOF_COMP  = 5'd16;
  localparam phase_t PH_SOS_HDR   = 5'd17;
  localparam phase_t PH_SOS_COMP  = 5'd18;
  localparam phase_t PH_SOS_TAIL  = 5'd19;

  // marker codes following the 0xFF prefix
  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_STUFF  = 8'h00;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_DQT    = 8'hDB;
  localparam logic [7:0] MK_DHT    = 8'hC4;
  localparam logic [7:0] MK_SOF0   = 8'hC0;
  localparam logic [7:0] MK_SOS    = 8'hDA;

  localparam logic [11:0] QUANT_ENTRIES = 12'd64;
  localparam logic [11:0] HUFF_COUNTS   = 12'd16;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } res_t;

endpackage

// ===== sv/jhp_if.sv =====
// ---------------------------------------------------------------------------
// JPEG header parser channels
// Byte stream into the parser and result records out of it.
// ---------------------------------------------------------------------------
interface jhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface jhp_rec_if;
  logic            valid;
  logic            ready;
  jhp_pkg::kind_t  kind;

  modport source (output valid, output kind, input ready);
  modport sink   (input valid, input kind, output ready);
endinterface

// ===== sv/jhp_core.sv =====
// ---------------------------------------------------------------------------
// JPEG header parser core
// Marker and segment state machine; one byte per enabled cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jhp_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic [7:0]    data_byte,
  output jhp_pkg::res_t res
);
  import jhp_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] remaining, remaining_next;
  logic [11:0] entry_count, entry_count_next;
  logic [12:0] symbol_total, symbol_total_next;
  logic        wide_entries, wide_entries_next;
  logic [7:0]  items_left, items_left_next;
  logic [7:0]  high_byte, high_byte_next;
  logic [2:0]  field_pos, field_pos_next;

  logic [16:0] seg_len;
  logic [15:0] len_body;
  logic [15:0] rem_dec;
  logic [11:0] count_inc;
  logic [12:0] sym_sum;
  logic [7:0]  items_dec;

  assign seg_len   = {1'b0, high_byte, data_byte};
  assign len_body  = (seg_len >= 17'd2) ? 16'(seg_len - 17'd2) : 16'd0;
  assign rem_dec   = (remaining != 16'd0) ? remaining - 16'd1 : 16'd0;
  assign count_inc = entry_count + 12'd1;
  assign sym_sum   = symbol_total + {5'd0, data_byte};
  assign items_dec = items_left - 8'd1;

  always_comb begin
    phase_next        = phase;
    remaining_next    = remaining;
    entry_count_next  = entry_count;
    symbol_total_next = symbol_total;
    wide_entries_next = wide_entries;
    items_left_next   = items_left;
    high_byte_next    = high_byte;
    field_pos_next    = field_pos;
    res.valid         = 1'b0;
    res.kind          = KIND_START;

    unique case (phase)
      PH_MARK: begin
        case (data_byte)
          MK_PREFIX: phase_next = PH_MARK;
          MK_SOI: begin
            res.valid  = 1'b1;
            res.kind   = KIND_START;
            phase_next = PH_SEARCH;
          end
          MK_EOI: begin
            res.valid  = 1'b1;
            res.kind   = KIND_END;
            phase_next = PH_DONE;
          end
          MK_STUFF: phase_next = PH_SEARCH;
          MK_DQT:   phase_next = PH_DQT_LH;
          MK_DHT:   phase_next = PH_DHT_LH;
          MK_SOF0: begin
            phase_next     = PH_SOF_HDR;
            field_pos_next = 3'd0;
          end
          MK_SOS: begin
            phase_next     = PH_SOS_HDR;
            field_pos_next = 3'd0;
          end
          default: phase_next = PH_SKIP_LH;
        endcase
      end
      PH_DONE: phase_next = PH_DONE;
      PH_SKIP_LH, PH_DQT_LH, PH_DHT_LH: begin
        high_byte_next = data_byte;
        phase_next     = phase + 5'd1;
      end
      PH_SKIP_LL, PH_DQT_LL, PH_DHT_LL: begin
        remaining_next = len_body;
        if (len_body == 16'd0) begin
          phase_next = PH_SEARCH;
        end else if (phase == PH_SKIP_LL) begin
          phase_next = PH_SKIP_BODY;
        end else begin
          phase_next = phase + 5'd1;
        end
      end
      PH_SKIP_BODY: begin
        remaining_next = rem_dec;
        if (rem_dec == 16'd0) phase_next = PH_SEARCH;
      end
      PH_DQT_INFO: begin
        wide_entries_next = (data_byte[7:4] != 4'd0);
        remaining_next    = rem_dec;
        entry_count_next  = 12'd0;
        field_pos_next    = 3'd0;
        phase_next        = PH_DQT_ENT;
      end
      PH_DQT_ENT: begin
        remaining_next = rem_dec;
        if (!wide_entries || field_pos == 3'd1) begin
          res.valid        = 1'b1;
          res.kind         = KIND_QUANT;
          field_pos_next   = 3'd0;
          entry_count_next = count_inc;
          if (count_inc >= QUANT_ENTRIES) begin
            phase_next = (rem_dec != 16'd0) ? PH_DQT_INFO : PH_SEARCH;
          end
        end else begin
          field_pos_next = 3'd1;
        end
      end
      PH_DHT_INFO: begin
        remaining_next    = rem_dec;
        entry_count_next  = 12'd0;
        symbol_total_next = 13'd0;
        phase_next        = PH_DHT_CNT;
      end
      PH_DHT_CNT: begin
        remaining_next    = rem_dec;
        symbol_total_next = sym_sum;
        res.valid         = 1'b1;
        res.kind          = KIND_HCOUNT;
        entry_count_next  = count_inc;
        if (count_inc >= HUFF_COUNTS) begin
          entry_count_next = 12'd0;
          if (sym_sum != 13'd0) begin
            phase_next = PH_DHT_SYM;
          end else begin
            phase_next = (rem_dec != 16'd0) ? PH_DHT_INFO : PH_SEARCH;
          end
        end
      end
      PH_DHT_SYM: begin
        remaining_next   = rem_dec;
        res.valid        = 1'b1;
        res.kind         = KIND_HSYMBOL;
        entry_count_next = count_inc;
        if ({1'b0, count_inc} >= symbol_total) begin
          phase_next = (rem_dec != 16'd0) ? PH_DHT_INFO : PH_SEARCH;
        end
      end
      PH_SOF_HDR: begin
        if (field_pos == 3'd6) begin
          res.valid = 1'b1;
          res.kind  = KIND_FRAME;
        end
        if (field_pos == 3'd7) begin
          items_left_next = data_byte;
          field_pos_next  = 3'd0;
          phase_next      = (data_byte != 8'd0) ? PH_SOF_COMP : PH_SEARCH;
        end else begin
          field_pos_next = field_pos + 3'd1;
        end
      end
      PH_SOF_COMP: begin
        if (field_pos == 3'd0) begin
          field_pos_next = 3'd1;
        end else if (field_pos == 3'd1) begin
          field_pos_next = 3'd2;
        end else begin
          res.valid       = 1'b1;
          res.kind        = KIND_COMP;
          field_pos_next  = 3'd0;
          items_left_next = items_dec;
          if (items_dec == 8'd0) phase_next = PH_SEARCH;
        end
      end
      PH_SOS_HDR: begin
        if (field_pos >= 3'd2) begin
          items_left_next = data_byte;
          field_pos_next  = 3'd0;
          phase_next      = (data_byte != 8'd0) ? PH_SOS_COMP : PH_SOS_TAIL;
        end else begin
          field_pos_next = field_pos + 3'd1;
        end
      end
      PH_SOS_COMP: begin
        if (field_pos == 3'd0) begin
          field_pos_next = 3'd1;
        end else begin
          res.valid       = 1'b1;
          res.kind        = KIND_SCAN;
          field_pos_next  = 3'd0;
          items_left_next = items_dec;
          if (items_dec == 8'd0) phase_next = PH_SOS_TAIL;
        end
      end
      PH_SOS_TAIL: begin
        if (field_pos >= 3'd2) begin
          field_pos_next = 3'd0;
          phase_next     = PH_SEARCH;
        end else begin
          field_pos_next = field_pos + 3'd1;
        end
      end
      default: begin
        phase_next = (data_byte == MK_PREFIX) ? PH_MARK : PH_SEARCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SEARCH;
      remaining    <= 16'd0;
      entry_count  <= 12'd0;
      symbol_total <= 13'd0;
      wide_entries <= 1'b0;
      items_left   <= 8'd0;
      high_byte    <= 8'd0;
      field_pos    <= 3'd0;
    end else if (fire) begin
      phase        <= phase_next;
      remaining    <= remaining_next;
      entry_count  <= entry_count_next;
      symbol_total <= symbol_total_next;
      wide_entries <= wide_entries_next;
      items_left   <= items_left_next;
      high_byte    <= high_byte_next;
      field_pos    <= field_pos_next;
    end
  end

  // end of image is final: silent and sticky
  `ASSERT_NEVER(a_done_silent, clk, rst, phase == PH_DONE && res.valid)
  `ASSERT_PROP(a_done_sticky, clk, rst, phase == PH_DONE |=> phase == PH_DONE)
  // a quant table never runs past its 64 entries
  `ASSERT_NEVER(a_dqt_bound, clk, rst, phase == PH_DQT_ENT && entry_count >= QUANT_ENTRIES)
  // symbol walk stays below the summed count
  `ASSERT_NEVER(a_sym_bound, clk, rst,
                phase == PH_DHT_SYM && {1'b0, entry_count} >= symbol_total)

endmodule

// ===== sv/jpeg_header_parser.sv =====
// ---------------------------------------------------------------------------
// JPEG header parser
// Walks the marker segments of a baseline JPEG byte stream and emits one
// record per decoded header field.
// ---------------------------------------------------------------------------
//  channel  | role   | payload             | meaning
//  ---------+--------+---------------------+---------------------------------
//  stream   | sink   | data_byte [7:0]     | next byte of the file
//  record   | source | kind [2:0]          | kind of header field decoded
//
//  One byte is taken per cycle while stream.ready is high; each accepted
//  byte updates the parser state in the same cycle and may load one record
//  into the output register, seen on record in the cycle after acceptance.
//  stream.ready is high whenever the output register is empty or is being
//  emptied in this cycle, so a waiting record holds back the stream only for
//  as long as record.ready stays low.
//  Reset (rst, synchronous) returns the parser to marker search and drops
//  any pending record.
// ---------------------------------------------------------------------------
module jpeg_header_parser (
  input  logic      clk,
  input  logic      rst,
  jhp_byte_if.sink  stream,
  jhp_rec_if.source record
);
  import jhp_pkg::*;

  res_t  res;
  logic  fire;
  logic  out_valid;
  kind_t out_kind;

  // take a byte while the result slot is free or draining
  assign stream.ready = !out_valid || record.ready;
  assign fire         = stream.valid && stream.ready;

  jhp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (stream.data_byte),
    .res       (res)
  );

  // output register: load on a new record, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res.valid) begin
      out_valid <= 1'b1;
    end else if (record.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_kind <= res.kind;
    end
  end

  assign record.valid = out_valid;
  assign record.kind  = out_kind;

endmodule
